>>> sv/pfer_pkg.sv
// Package for the pulse frame edge reconstructor.
// Holds item and result types, scan state types and shared constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pfer_pkg;

  // Field widths
  localparam int DUR_W    = 15;
  localparam int SYM_W    = 7;
  localparam int TICK_W   = 22;
  localparam int IDLE_W   = 20;
  localparam int TIME_W   = 64;
  localparam int CNT_W    = 32;
  localparam int BACK_W   = 23;   // idle window plus tick sum

  // Defaults and limits
  localparam int unsigned WORDS_PER_FRAME_DEF = 48;
  localparam logic [IDLE_W-1:0] IDLE_RESET = IDLE_W'(10000);
  localparam logic [SYM_W-1:0]  SYM_MAX    = {SYM_W{1'b1}};
  localparam logic [TICK_W-1:0] TICK_MAX   = {TICK_W{1'b1}};

  // One lane for each half of a capture word
  localparam int LANES = 2;

  // Opcodes
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_ERROR   = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [DUR_W-1:0]  duration_first;
    logic              level_first;
    logic [DUR_W-1:0]  duration_second;
    logic              level_second;
    logic              frame_end;
    logic [TIME_W-1:0] now_us;
    logic              owner_fault;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] edge_us;
    logic [DUR_W-1:0]  width_us;
    logic [SYM_W-1:0]  symbol_count;
    logic              frame_empty;
    logic [CNT_W-1:0]  frames_seen;
    logic [CNT_W-1:0]  data_frames;
    logic [CNT_W-1:0]  empty_frames;
    logic [CNT_W-1:0]  owner_errors;
  } result_t;

  // What one lane found in its half
  typedef struct packed {
    logic             take;
    logic             high;
    logic [DUR_W-1:0] dur;
  } lane_hit_t;

  // Scan state of the current frame (word count kept apart, its width is a parameter)
  typedef struct packed {
    logic              stopped;
    logic [SYM_W-1:0]  symbols;
    logic [TICK_W-1:0] ticks;
    logic [DUR_W-1:0]  first_width;
    logic              high_seen;
  } scan_state_t;

  // Frame summary waiting for the edge subtract
  typedef struct packed {
    logic [TIME_W-1:0] now_us;
    logic [BACK_W-1:0] back;
    logic              empty;
    logic [DUR_W-1:0]  width;
    logic [SYM_W-1:0]  symbols;
    logic [CNT_W-1:0]  frames_seen;
    logic [CNT_W-1:0]  data_frames;
    logic [CNT_W-1:0]  empty_frames;
    logic [CNT_W-1:0]  owner_errors;
  } frame_sum_t;

endpackage

`default_nettype wire

>>> sv/pfer_lane.sv
// One half-word lane of the pulse frame edge reconstructor.
// Decides whether its half is a symbol and whether it is a high one.
// Depends on pfer_pkg.
`default_nettype none

module pfer_lane (
  input  logic                     enable,
  input  logic [pfer_pkg::DUR_W-1:0] dur,
  input  logic                     level,
  output pfer_pkg::lane_hit_t      hit
);
  import pfer_pkg::*;

  // A nonzero half in an active scan counts as a symbol
  always_comb begin
    hit.take = enable && (dur != '0);
    hit.high = enable && (dur != '0) && level;
    hit.dur  = enable ? dur : '0;
  end

endmodule

`default_nettype wire

>>> sv/pfer_merge.sv
// Merge stage of the pulse frame edge reconstructor.
// Combines the lane hits into the next scan state with saturation.
// Depends on pfer_pkg.
`default_nettype none

module pfer_merge #(
  parameter int unsigned WORDS_PER_FRAME = pfer_pkg::WORDS_PER_FRAME_DEF,
  parameter int          WCNT_W          = $clog2(WORDS_PER_FRAME + 1)
) (
  input  logic                  active,
  input  logic                  second_zero,
  input  pfer_pkg::scan_state_t scan,
  input  logic [WCNT_W-1:0]     words,
  input  pfer_pkg::lane_hit_t   hits [pfer_pkg::LANES],
  output pfer_pkg::scan_state_t scan_next,
  output logic [WCNT_W-1:0]     words_next
);
  import pfer_pkg::*;

  logic [1:0]        takes;
  logic [SYM_W:0]    sym_sum;
  logic [TICK_W+1:0] tick_sum;
  logic [WCNT_W-1:0] words_inc;
  logic              hi_found;
  logic [DUR_W-1:0]  hi_dur;

  // Count, sum and first high over the lanes; lane 0 has priority
  always_comb begin
    takes    = '0;
    tick_sum = {2'b00, scan.ticks};
    hi_found = 1'b0;
    hi_dur   = '0;
    for (int i = 0; i < LANES; i++) begin
      takes    = takes + 2'(hits[i].take);
      tick_sum = tick_sum + (TICK_W+2)'(hits[i].dur);
      if (!hi_found && hits[i].high) begin
        hi_found = 1'b1;
        hi_dur   = hits[i].dur;
      end
    end
    sym_sum = {1'b0, scan.symbols} + (SYM_W+1)'(takes);
  end

  assign words_inc = words + WCNT_W'(1);

  // Next scan state
  always_comb begin
    scan_next         = scan;
    words_next        = words;
    scan_next.symbols = (sym_sum > (SYM_W+1)'(SYM_MAX)) ? SYM_MAX : sym_sum[SYM_W-1:0];
    scan_next.ticks   = (tick_sum > (TICK_W+2)'(TICK_MAX)) ? TICK_MAX
                                                           : tick_sum[TICK_W-1:0];
    if (!scan.high_seen && hi_found) begin
      scan_next.high_seen   = 1'b1;
      scan_next.first_width = hi_dur;
    end
    if (active) begin
      words_next = words_inc;
      if (second_zero || (words_inc >= WCNT_W'(WORDS_PER_FRAME))) begin
        scan_next.stopped = 1'b1;
      end
    end else if (!scan.stopped) begin
      // word limit already reached
      scan_next.stopped = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> sv/pfer_edge.sv
// Edge time stage of the pulse frame edge reconstructor.
// Subtracts idle window plus tick sum from the frame end time.
// Depends on pfer_pkg.
`default_nettype none

module pfer_edge (
  input  pfer_pkg::frame_sum_t sum,
  output pfer_pkg::result_t    res
);
  import pfer_pkg::*;

  logic [TIME_W:0] diff;
  logic            now_gt;

  // Borrow out gives now < back; strictly greater also needs a nonzero difference
  assign diff   = {1'b0, sum.now_us} - (TIME_W+1)'(sum.back);
  assign now_gt = !diff[TIME_W] && (diff[TIME_W-1:0] != '0);

  always_comb begin
    res.edge_us      = sum.empty ? '0 : (now_gt ? diff[TIME_W-1:0] : sum.now_us);
    res.width_us     = sum.empty ? '0 : sum.width;
    res.symbol_count = sum.empty ? '0 : sum.symbols;
    res.frame_empty  = sum.empty;
    res.frames_seen  = sum.frames_seen;
    res.data_frames  = sum.data_frames;
    res.empty_frames = sum.empty_frames;
    res.owner_errors = sum.owner_errors;
  end

endmodule

`default_nettype wire

>>> sv/pulse_frame_edge_reconstructor.sv
// Top level of the pulse frame edge reconstructor.
// Instantiates two half-word lanes, the merge stage and the edge stage.
// Depends on pfer_pkg, pfer_lane, pfer_merge, pfer_edge.
//
//   channel | signals                      | direction | carries
//   --------+------------------------------+-----------+--------------------------
//   in      | in_valid, in_stall, in_data  | in        | capture word or error event
//   out     | out_valid, out_stall, out_data| out      | one frame result
//   cfg     | cfg_valid, cfg_ready, cfg_data| in       | idle window write
//
// One item is taken every cycle while in_stall is low. Both halves of a word
// are scanned in the same cycle by parallel lanes; the scan state updates at
// the accept edge. A frame result passes the frame summary register, then the
// output register after the 64-bit edge subtract, on its way to out_data.
// Reset clears scan state and counters and sets the idle window to 10000.
// in_stall rises only while both result registers are held by out_stall.
`default_nettype none

module pulse_frame_edge_reconstructor #(
  parameter int unsigned WORDS_PER_FRAME = pfer_pkg::WORDS_PER_FRAME_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pfer_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pfer_pkg::result_t           out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pfer_pkg::IDLE_W-1:0] cfg_data
);
  import pfer_pkg::*;

  localparam int WCNT_W = $clog2(WORDS_PER_FRAME + 1);

  logic [IDLE_W-1:0] idle_ticks;
  scan_state_t       scan, scan_next, scan_merged;
  logic [WCNT_W-1:0] words, words_next, words_merged;
  logic [CNT_W-1:0]  frames, frames_next;
  logic [CNT_W-1:0]  data_cnt, data_cnt_next;
  logic [CNT_W-1:0]  empty_cnt, empty_cnt_next;
  logic [CNT_W-1:0]  owner_cnt, owner_cnt_next;

  logic       mid_valid;
  frame_sum_t mid, mid_next;
  result_t    edge_res;

  logic       out_free, mid_adv, acc, is_err, is_result, active, empty_now;
  lane_hit_t  hits [LANES];
  logic [DUR_W-1:0] lane_dur [LANES];
  logic             lane_lvl [LANES];

  // Handshake and pipeline advance
  assign out_free  = !out_valid || !out_stall;
  assign mid_adv   = mid_valid && out_free;
  assign in_stall  = mid_valid && !out_free;
  assign acc       = in_valid && !in_stall;
  assign is_err    = in_data.opcode == OP_ERROR;
  assign is_result = !is_err && in_data.frame_end;
  assign cfg_ready = 1'b1;

  // Lanes, one per half of the word
  assign active      = !scan.stopped && (words < WCNT_W'(WORDS_PER_FRAME));
  assign lane_dur[0] = in_data.duration_first;
  assign lane_lvl[0] = in_data.level_first;
  assign lane_dur[1] = in_data.duration_second;
  assign lane_lvl[1] = in_data.level_second;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pfer_lane u_lane (
      .enable (active),
      .dur    (lane_dur[g]),
      .level  (lane_lvl[g]),
      .hit    (hits[g])
    );
  end

  pfer_merge #(
    .WORDS_PER_FRAME (WORDS_PER_FRAME),
    .WCNT_W          (WCNT_W)
  ) u_merge (
    .active      (active),
    .second_zero (in_data.duration_second == '0),
    .scan        (scan),
    .words       (words),
    .hits        (hits),
    .scan_next   (scan_merged),
    .words_next  (words_merged)
  );

  // Frame end bookkeeping and next state
  assign empty_now = scan_merged.symbols == '0;

  always_comb begin
    scan_next      = scan_merged;
    words_next     = words_merged;
    frames_next    = frames;
    data_cnt_next  = data_cnt;
    empty_cnt_next = empty_cnt;
    owner_cnt_next = owner_cnt;
    if (is_err) begin
      owner_cnt_next = owner_cnt + CNT_W'(1);
      scan_next      = '0;
      words_next     = '0;
    end else if (in_data.frame_end) begin
      frames_next = frames + CNT_W'(1);
      if (empty_now) begin
        empty_cnt_next = empty_cnt + CNT_W'(1);
      end else begin
        data_cnt_next = data_cnt + CNT_W'(1);
      end
      if (in_data.owner_fault) begin
        owner_cnt_next = owner_cnt + CNT_W'(1);
      end
      scan_next  = '0;
      words_next = '0;
    end
  end

  // Frame summary for the edge stage
  always_comb begin
    mid_next.now_us       = in_data.now_us;
    mid_next.back         = BACK_W'(idle_ticks) + BACK_W'(scan_merged.ticks);
    mid_next.empty        = empty_now;
    mid_next.width        = scan_merged.first_width;
    mid_next.symbols      = scan_merged.symbols;
    mid_next.frames_seen  = frames_next;
    mid_next.data_frames  = data_cnt_next;
    mid_next.empty_frames = empty_cnt_next;
    mid_next.owner_errors = owner_cnt_next;
  end

  pfer_edge u_edge (
    .sum (mid),
    .res (edge_res)
  );

  // Config and scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks <= IDLE_RESET;
      scan       <= '0;
      words      <= '0;
      frames     <= '0;
      data_cnt   <= '0;
      empty_cnt  <= '0;
      owner_cnt  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        idle_ticks <= cfg_data;
      end
      if (acc) begin
        scan      <= scan_next;
        words     <= words_next;
        frames    <= frames_next;
        data_cnt  <= data_cnt_next;
        empty_cnt <= empty_cnt_next;
        owner_cnt <= owner_cnt_next;
      end
    end
  end

  // Summary and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc && is_result) begin
        mid_valid <= 1'b1;
      end else if (mid_adv) begin
        mid_valid <= 1'b0;
      end
      if (mid_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_result) begin
      mid <= mid_next;
    end
    if (mid_adv) begin
      out_data <= edge_res;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/pulse_frame_edge_reconstructor_tb.sv
// Testbench for pulse_frame_edge_reconstructor: directed table, then random frames.
// Predicts every frame result in SystemVerilog and checks each output item in order.
// Depends on pfer_pkg and the block's RTL.
`timescale 1ns / 100ps

module pulse_frame_edge_reconstructor_tb;
  import pfer_pkg::*;

  localparam int unsigned WPF = WORDS_PER_FRAME_DEF;
  localparam int ITEMS_PER_BLOCK = 170;
  localparam int DRAIN_PAD = 8;
  localparam int HOLD_CYCLES = 120;
  localparam int QUIET_LIMIT = 3000;
  localparam result_t NO_RESULT = '0;

  typedef struct packed {
    in_item_t item;
    logic     has_want;
    result_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  result_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDLE_W-1:0] cfg_data;

  // Typed expectation travels alongside the payload of directed rows
  logic row_has_want;
  result_t row_want;

  // Idling control for sender and receiver, then item, quiet and mismatch counters
  int send_pct;
  int recv_pct;
  int hold_tokens = 0;
  int item_count = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;

  result_t expected_frames[$];

  // Predicted scan state and configuration
  logic              scan_stop_q;
  int unsigned       words_q;
  logic [SYM_W-1:0]  symbols_q;
  logic [TICK_W-1:0] ticks_q;
  logic [DUR_W-1:0]  first_width_q;
  logic              high_seen_q;
  logic [CNT_W-1:0]  frames_q, data_frames_q, empty_frames_q, owner_err_q;
  logic [IDLE_W-1:0] idle_win_q;

  pulse_frame_edge_reconstructor #(.WORDS_PER_FRAME(WPF)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t word_item(input logic op, input logic [DUR_W-1:0] d0,
                                         input logic l0, input logic [DUR_W-1:0] d1,
                                         input logic l1, input logic fe,
                                         input logic [TIME_W-1:0] now_v, input logic fault);
    in_item_t it;
    it.opcode          = op;
    it.duration_first  = d0;
    it.level_first     = l0;
    it.duration_second = d1;
    it.level_second    = l1;
    it.frame_end       = fe;
    it.now_us          = now_v;
    it.owner_fault     = fault;
    return it;
  endfunction

  function automatic result_t frame_res(input logic [TIME_W-1:0] e_us,
                                        input logic [DUR_W-1:0] w_us,
                                        input logic [SYM_W-1:0] syms, input logic empty,
                                        input logic [CNT_W-1:0] fs, input logic [CNT_W-1:0] dfr,
                                        input logic [CNT_W-1:0] efr, input logic [CNT_W-1:0] oe);
    result_t r;
    r.edge_us      = e_us;
    r.width_us     = w_us;
    r.symbol_count = syms;
    r.frame_empty  = empty;
    r.frames_seen  = fs;
    r.data_frames  = dfr;
    r.empty_frames = efr;
    r.owner_errors = oe;
    return r;
  endfunction

  function automatic logic [DUR_W-1:0] rand_dur();
    logic [DUR_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 15'h7FFF;
      1: v = 15'd1;
      2: v = DUR_W'($urandom_range(1, 15));
      default: v = DUR_W'($urandom_range(1, 32767));
    endcase
    return v;
  endfunction

  // Mix of full-range, 32-bit, small (underflow side) and near-top frame end times
  function automatic logic [TIME_W-1:0] rand_now();
    logic [TIME_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = {$urandom, $urandom};
      1: v = TIME_W'($urandom_range(0, 2000000));
      2: v = 64'hFFFF_FFFF_FFFF_FFFF - TIME_W'($urandom_range(0, 5000));
      default: v = {32'h0, $urandom};
    endcase
    return v;
  endfunction

  // ---------------- predictor ----------------

  task automatic clear_scan_state();
    scan_stop_q   = 1'b0;
    words_q       = 0;
    symbols_q     = '0;
    ticks_q       = '0;
    first_width_q = '0;
    high_seen_q   = 1'b0;
  endtask

  task automatic take_half(input logic [DUR_W-1:0] dur, input logic lvl);
    logic [TICK_W:0] sum;
    if (symbols_q != SYM_MAX) symbols_q = symbols_q + 1'b1;
    sum = {1'b0, ticks_q} + {8'b0, dur};
    ticks_q = (sum > {1'b0, TICK_MAX}) ? TICK_MAX : sum[TICK_W-1:0];
    if (!high_seen_q && lvl) begin
      first_width_q = dur;
      high_seen_q   = 1'b1;
    end
  endtask

  // Advance the scan by one item; emit is set on the frame end of a capture item
  task automatic predict_frame_word(input in_item_t it, output logic emit, output result_t r);
    logic [TIME_W-1:0] back;
    logic [TIME_W-1:0] e_us;
    logic empty;
    emit = 1'b0;
    r    = NO_RESULT;
    if (it.opcode == OP_ERROR) begin
      owner_err_q = owner_err_q + 1'b1;
      clear_scan_state();
    end else begin
      if (!scan_stop_q) begin
        if (words_q >= WPF) begin
          scan_stop_q = 1'b1;
        end else begin
          words_q++;
          if (it.duration_first == '0 && it.duration_second == '0) begin
            scan_stop_q = 1'b1;
          end else begin
            if (it.duration_first != '0) take_half(it.duration_first, it.level_first);
            if (it.duration_second != '0) take_half(it.duration_second, it.level_second);
            else scan_stop_q = 1'b1;
            if (words_q >= WPF) scan_stop_q = 1'b1;
          end
        end
      end
      if (it.frame_end) begin
        frames_q = frames_q + 1'b1;
        empty = (symbols_q == '0);
        e_us = '0;
        if (empty) begin
          empty_frames_q = empty_frames_q + 1'b1;
        end else begin
          data_frames_q = data_frames_q + 1'b1;
          back = {44'b0, idle_win_q} + {42'b0, ticks_q};
          e_us = (it.now_us > back) ? it.now_us - back : it.now_us;
        end
        if (it.owner_fault) owner_err_q = owner_err_q + 1'b1;
        r = frame_res(e_us, empty ? '0 : first_width_q, empty ? '0 : symbols_q, empty,
                      frames_q, data_frames_q, empty_frames_q, owner_err_q);
        emit = 1'b1;
        clear_scan_state();
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // ---------------- scoreboard ----------------

  always @(posedge clk) begin : scoreboard
    result_t want;
    result_t predicted;
    logic emit;
    logic moved;
    if (rst) begin
      clear_scan_state();
      frames_q       = '0;
      data_frames_q  = '0;
      empty_frames_q = '0;
      owner_err_q    = '0;
      idle_win_q     = IDLE_RESET;
      quiet_cycles   = 0;
    end else begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        idle_win_q = cfg_data;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_frames.size() == 0) begin
          $display("%0t: result item with none expected, actual %h", $time, out_data);
          mismatch_count++;
        end else begin
          want = expected_frames.pop_front();
          check_field("edge_us", want.edge_us, out_data.edge_us);
          check_field("width_us", 64'(want.width_us), 64'(out_data.width_us));
          check_field("symbol_count", 64'(want.symbol_count), 64'(out_data.symbol_count));
          check_field("frame_empty", 64'(want.frame_empty), 64'(out_data.frame_empty));
          check_field("frames_seen", 64'(want.frames_seen), 64'(out_data.frames_seen));
          check_field("data_frames", 64'(want.data_frames), 64'(out_data.data_frames));
          check_field("empty_frames", 64'(want.empty_frames), 64'(out_data.empty_frames));
          check_field("owner_errors", 64'(want.owner_errors), 64'(out_data.owner_errors));
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        predict_frame_word(in_data, emit, predicted);
        if (emit) expected_frames.push_back(row_has_want ? row_want : predicted);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // ---------------- receiver ----------------

  always @(posedge clk) begin : receiver
    int hold_left;
    int hold_served;
    if (rst) begin
      hold_left   = 0;
      hold_served = 0;
    end
    if (hold_left == 0 && hold_served != hold_tokens) begin
      hold_served = hold_tokens;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_pct != 0) && ($urandom_range(0, 99) < recv_pct);
    end
  end

  // ---------------- watchdog ----------------

  initial begin : watchdog
    @(posedge clk);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------- sender ----------------

  task automatic send_item(input in_item_t it, input logic has, input result_t want);
    int gap;
    if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      gap = 1;
      while ($urandom_range(0, 99) < send_pct) gap++;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data      <= it;
    row_has_want <= has;
    row_want     <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item_count++;
  endtask

  // Wait until every expected result has come, plus pipeline slack;
  // the first edge lets the scoreboard queue the last accepted item
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_idle(input logic [IDLE_W-1:0] v);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One frame of capture words with random content, early stops and error events
  task automatic send_frame();
    int n;
    int w;
    in_item_t it;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(WPF - 2, WPF + 6) : $urandom_range(1, 6);
    for (w = 0; w < n; w++) begin
      if (w != n - 1 && $urandom_range(0, 29) == 0)
        send_item(word_item(OP_ERROR, DUR_W'($urandom), 1'($urandom), DUR_W'($urandom),
                            1'($urandom), 1'($urandom), rand_now(), 1'($urandom)),
                  1'b0, NO_RESULT);
      it = word_item(OP_CAPTURE, rand_dur(), 1'($urandom), rand_dur(), 1'($urandom),
                     w == n - 1, rand_now(), $urandom_range(0, 7) == 0);
      case ($urandom_range(0, 24))
        0: it.duration_second = '0;
        1: begin
          it.duration_first  = '0;
          it.duration_second = '0;
        end
        2: it.duration_first = '0;
        default: ;
      endcase
      send_item(it, 1'b0, NO_RESULT);
    end
  endtask

  initial begin : stimulus
    dir_row_t rows[$];
    logic [IDLE_W-1:0] idle_v;
    int p;
    int s;
    int i;
    int target;
    in_valid     <= 1'b0;
    in_data      <= '0;
    row_has_want <= 1'b0;
    row_want     <= NO_RESULT;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    rst          <= 1'b1;
    send_pct = 29;
    recv_pct = 49;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table, idle window at its reset value
    // empty frame right after reset
    rows.push_back({word_item(OP_CAPTURE, 15'd0, 1'b0, 15'd0, 1'b0, 1'b1, 64'd0, 1'b0),
                    1'b1, frame_res(64'd0, 15'd0, 7'd0, 1'b1, 1, 0, 1, 0)});
    // error event with every other field set
    rows.push_back({word_item(OP_ERROR, 15'h7FFF, 1'b1, 15'h7FFF, 1'b1, 1'b1, '1, 1'b1),
                    1'b0, NO_RESULT});
    // max durations, then max time and owner fault
    rows.push_back({word_item(OP_CAPTURE, 15'h7FFF, 1'b1, 15'h7FFF, 1'b0, 1'b0, 64'd0, 1'b0),
                    1'b0, NO_RESULT});
    rows.push_back({word_item(OP_CAPTURE, 15'd1, 1'b0, 15'd1, 1'b1, 1'b1, '1, 1'b1),
                    1'b1, frame_res(64'hFFFF_FFFF_FFFE_D8EF, 15'h7FFF, 7'd4, 1'b0, 2, 1, 1, 2)});
    // underflow: edge falls back to now
    rows.push_back({word_item(OP_CAPTURE, 15'd100, 1'b1, 15'd0, 1'b1, 1'b1, 64'd5, 1'b0),
                    1'b1, frame_res(64'd5, 15'd100, 7'd1, 1'b0, 3, 2, 1, 2)});
    // now equal to idle plus ticks, then one above
    rows.push_back({word_item(OP_CAPTURE, 15'd50, 1'b0, 15'd50, 1'b0, 1'b1, 64'd10100, 1'b0),
                    1'b1, frame_res(64'd10100, 15'd0, 7'd2, 1'b0, 4, 3, 1, 2)});
    rows.push_back({word_item(OP_CAPTURE, 15'd50, 1'b0, 15'd50, 1'b0, 1'b1, 64'd10101, 1'b0),
                    1'b1, frame_res(64'd1, 15'd0, 7'd2, 1'b0, 5, 4, 1, 2)});
    // error in the middle of a frame clears the scan
    rows.push_back({word_item(OP_CAPTURE, 15'd7, 1'b1, 15'd9, 1'b1, 1'b0, 64'd0, 1'b0),
                    1'b0, NO_RESULT});
    rows.push_back({word_item(OP_ERROR, 15'd0, 1'b0, 15'd0, 1'b0, 1'b0, 64'd0, 1'b0),
                    1'b0, NO_RESULT});
    rows.push_back({word_item(OP_CAPTURE, 15'd0, 1'b0, 15'd0, 1'b0, 1'b1, 64'd1234, 1'b1),
                    1'b1, frame_res(64'd0, 15'd0, 7'd0, 1'b1, 6, 4, 2, 4)});
    // zero first half only
    rows.push_back({word_item(OP_CAPTURE, 15'd0, 1'b1, 15'd200, 1'b1, 1'b1,
                              64'h0123_4567_89AB_CDEF, 1'b0), 1'b0, NO_RESULT});
    // stop on zero second half, later words ignored until frame end
    rows.push_back({word_item(OP_CAPTURE, 15'd10, 1'b0, 15'd0, 1'b0, 1'b0, 64'd0, 1'b0),
                    1'b0, NO_RESULT});
    rows.push_back({word_item(OP_CAPTURE, 15'd500, 1'b1, 15'd500, 1'b1, 1'b0, 64'd0, 1'b0),
                    1'b0, NO_RESULT});
    rows.push_back({word_item(OP_CAPTURE, 15'd5, 1'b1, 15'd5, 1'b1, 1'b1,
                              64'h8000_0000_0000_0000, 1'b0), 1'b0, NO_RESULT});
    // stop on an all-zero word
    rows.push_back({word_item(OP_CAPTURE, 15'd3, 1'b0, 15'd4, 1'b1, 1'b0, 64'd0, 1'b0),
                    1'b0, NO_RESULT});
    rows.push_back({word_item(OP_CAPTURE, 15'd0, 1'b0, 15'd0, 1'b0, 1'b0, 64'd0, 1'b0),
                    1'b0, NO_RESULT});
    rows.push_back({word_item(OP_CAPTURE, 15'd9, 1'b1, 15'd9, 1'b1, 1'b1, 64'd1000000, 1'b0),
                    1'b0, NO_RESULT});
    // single max word, now at zero
    rows.push_back({word_item(OP_CAPTURE, 15'h7FFF, 1'b1, 15'h7FFF, 1'b1, 1'b1, 64'd0, 1'b0),
                    1'b0, NO_RESULT});
    rows.push_back({word_item(OP_ERROR, 15'd0, 1'b0, 15'd0, 1'b0, 1'b0, 64'd0, 1'b0),
                    1'b0, NO_RESULT});
    for (i = 0; i < rows.size(); i++) send_item(rows[i].item, rows[i].has_want, rows[i].want);

    // Random part: three idling phases, several idle window settings each
    for (p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_pct = 29;
          recv_pct = 49;
        end
        1: begin
          send_pct = 49;
          recv_pct = 29;
        end
        default: begin
          send_pct = 0;
          recv_pct = 0;
        end
      endcase
      for (s = 0; s < 3; s++) begin
        case (p * 3 + s)
          0: idle_v = '0;
          1: idle_v = 20'hFFFFF;
          2: idle_v = 20'd1000000;
          3: idle_v = 20'd1;
          5: idle_v = IDLE_RESET;
          7: idle_v = IDLE_W'($urandom_range(0, 1000));
          8: idle_v = 20'hFFFFF;
          default: idle_v = IDLE_W'($urandom);
        endcase
        write_idle(idle_v);
        // receiver holds off while single-word frames keep coming
        if (p == 2 && s == 0) begin
          hold_tokens++;
          repeat (30)
            send_item(word_item(OP_CAPTURE, rand_dur(), 1'($urandom), rand_dur(), 1'($urandom),
                                1'b1, rand_now(), 1'b0), 1'b0, NO_RESULT);
        end
        target = item_count + ITEMS_PER_BLOCK;
        while (item_count < target) begin
          if ($urandom_range(0, 99) < 80)
            send_frame();
          else
            send_item(word_item($urandom_range(0, 3) == 0, DUR_W'($urandom), 1'($urandom),
                                DUR_W'($urandom), 1'($urandom), $urandom_range(0, 3) == 0,
                                {$urandom, $urandom}, 1'($urandom)), 1'b0, NO_RESULT);
        end
      end
    end

    wait_drain();
    if (mismatch_count == 0 && expected_frames.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
sv/pfer_pkg.sv
sv/pfer_lane.sv
sv/pfer_merge.sv
sv/pfer_edge.sv
sv/pulse_frame_edge_reconstructor.sv
tb/sv/pulse_frame_edge_reconstructor_tb.sv
